@@ sv/ccdp_pkg.sv @@
package ccdp_pkg;

  localparam int NAME_BYTES = 16;
  localparam int NAME_LEN_W = $clog2(NAME_BYTES + 2);
  localparam int NAME_IDX_W = $clog2(NAME_BYTES);

  localparam logic [31:0] SAT_SECS = 32'h8000_0000;
  localparam logic [31:0] NO_LIMIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_NAME = 2'd1,
    PH_ARG  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    D_NO_CACHE, D_NO_STORE, D_NO_TRANSFORM, D_ONLY_IF_CACHED, D_MAX_AGE,
    D_MIN_FRESH, D_MAX_STALE, D_MUST_REVAL, D_PROXY_REVAL, D_PRIVATE,
    D_PUBLIC, D_S_MAXAGE, D_NONE
  } dir_t;

  // directive event passed from front to back
  typedef struct packed {
    logic        last;
    logic        resp;
    dir_t        id;
    logic        arg_nonempty;
    logic        arg_ok;
    logic [31:0] arg_val;
  } evt_t;

  typedef struct packed {
    logic        validate_first;
    logic        store_denied;
    logic        transform_denied;
    logic        cached_only;
    logic        stale_denied;
    logic        is_public;
    logic        max_age_present;
    logic [31:0] max_age_secs;
    logic        min_fresh_present;
    logic [31:0] min_fresh_secs;
    logic        max_stale_present;
    logic [31:0] max_stale_secs;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int dir_len(input dir_t d);
    case (d)
      D_NO_CACHE, D_NO_STORE, D_S_MAXAGE: return 8;
      D_NO_TRANSFORM: return 12;
      D_ONLY_IF_CACHED: return 14;
      D_MAX_AGE, D_PRIVATE: return 7;
      D_MIN_FRESH, D_MAX_STALE: return 9;
      D_MUST_REVAL: return 15;
      D_PROXY_REVAL: return 16;
      D_PUBLIC: return 6;
      default: return 0;
    endcase
  endfunction

  // names are right-aligned in the vector, first character highest
  function automatic logic [7:0] dir_char(input dir_t d, input int i);
    logic [127:0] s;
    case (d)
      D_NO_CACHE: s = "no-cache";
      D_NO_STORE: s = "no-store";
      D_NO_TRANSFORM: s = "no-transform";
      D_ONLY_IF_CACHED: s = "only-if-cached";
      D_MAX_AGE: s = "max-age";
      D_MIN_FRESH: s = "min-fresh";
      D_MAX_STALE: s = "max-stale";
      D_MUST_REVAL: s = "must-revalidate";
      D_PROXY_REVAL: s = "proxy-revalidate";
      D_PRIVATE: s = "private";
      D_PUBLIC: s = "public";
      D_S_MAXAGE: s = "s-maxage";
      default: s = '0;
    endcase
    if (i < dir_len(d)) return s[8 * (dir_len(d) - 1 - i) +: 8];
    return 8'd0;
  endfunction

endpackage

@@ sv/ccdp_front.sv @@
module ccdp_front import ccdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  header_byte,
  input  logic        is_response,
  input  logic        last_byte,
  output logic        evt_valid,
  input  logic        evt_ready,
  output evt_t        evt
);

  logic [7:0]            name_buffer [NAME_BYTES];
  logic [NAME_LEN_W-1:0] name_length;
  logic                  name_bad;
  phase_t                phase;
  logic                  pending;
  logic [31:0]           arg_value;
  logic                  st_started, st_quoted, st_closed, st_neg, st_nonempty, st_err;
  logic [1:0]            aph;

  logic       acc, ws, comma, eq, finish, append;
  logic [31:0] val_next;
  logic [35:0] prod;
  logic        a_started, a_quoted, a_closed, a_neg, a_nonempty, a_err;
  logic [1:0]  a_ph;
  dir_t        id;
  logic        ok;
  logic [7:0]            nb [NAME_BYTES];
  logic [NAME_LEN_W-1:0] nlen;
  logic                  nbad;

  assign ready = !evt_valid || evt_ready;
  assign acc   = valid && ready;
  assign ws    = is_ws(header_byte);
  assign comma = header_byte == 8'd44;
  assign eq    = header_byte == 8'd61;

  // name as it stands once this byte is taken
  always_comb begin
    for (int i = 0; i < NAME_BYTES; i++)
      nb[i] = (append && name_length == NAME_LEN_W'(i)) ? header_byte : name_buffer[i];
    nlen = (append && name_length <= NAME_LEN_W'(NAME_BYTES)) ? name_length + 1'b1
                                                               : name_length;
    nbad = name_bad || (phase == PH_NAME && pending && !ws && !comma);
  end

  always_comb begin
    id = D_NONE;
    ok = 1'b0;
    if (!nbad && nlen <= NAME_LEN_W'(NAME_BYTES)) begin
      for (int d = 0; d < int'(D_NONE); d++) begin
        ok = (NAME_LEN_W'(dir_len(dir_t'(d))) == nlen);
        for (int i = 0; i < NAME_BYTES; i++)
          if (i < dir_len(dir_t'(d)) && nb[i] != dir_char(dir_t'(d), i)) ok = 1'b0;
        if (ok) id = dir_t'(d);
      end
    end
  end

  // argument decoder step
  always_comb begin
    a_started = st_started; a_quoted = st_quoted; a_closed = st_closed;
    a_neg = st_neg; a_nonempty = st_nonempty || !ws; a_err = st_err; a_ph = aph;
    val_next = arg_value;
    prod = {4'd0, arg_value} * 36'd10 + {28'd0, header_byte - 8'd48};
    if (!st_started && header_byte == 8'd34) begin
      a_started = 1'b1; a_quoted = 1'b1;
    end else if (st_quoted && st_closed) begin
      a_started = 1'b1;
      if (!ws) a_err = 1'b1;
    end else if (st_quoted && header_byte == 8'd34) begin
      a_started = 1'b1; a_closed = 1'b1;
    end else begin
      a_started = 1'b1;
      if (ws) begin
        if (aph == 2'd1) a_err = 1'b1;
        else if (aph == 2'd2) a_ph = 2'd3;
      end else if (header_byte == 8'd43 || header_byte == 8'd45) begin
        if (aph == 2'd0) begin
          a_ph = 2'd1;
          if (header_byte == 8'd45) a_neg = 1'b1;
        end else a_err = 1'b1;
      end else if (header_byte >= 8'd48 && header_byte <= 8'd57) begin
        if (aph == 2'd3) a_err = 1'b1;
        else begin
          val_next = (prod > {4'd0, SAT_SECS}) ? SAT_SECS : prod[31:0];
          a_ph = 2'd2;
        end
      end else a_err = 1'b1;
    end
  end

  always_comb begin
    finish = comma || last_byte;
    append = 1'b0;
    case (phase)
      PH_LEAD: append = !ws && !comma && !eq;
      PH_NAME: append = !ws && !comma && !eq;
      default: append = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (acc) begin
      evt_valid <= finish;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
    if (acc && finish) begin
      evt.last         <= last_byte;
      evt.resp         <= is_response;
      evt.id           <= id;
      evt.arg_nonempty <= (phase == PH_ARG && !comma) ? a_nonempty : st_nonempty;
      if (phase == PH_ARG && !comma) begin
        evt.arg_ok  <= !a_err && a_ph >= 2'd2 && !(a_quoted && !a_closed)
                       && !(a_neg && val_next != 32'd0);
        evt.arg_val <= val_next;
      end else begin
        evt.arg_ok  <= !st_err && aph >= 2'd2 && !(st_quoted && !st_closed)
                       && !(st_neg && arg_value != 32'd0);
        evt.arg_val <= arg_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0; name_bad <= 1'b0; phase <= PH_LEAD; pending <= 1'b0;
      arg_value <= '0; aph <= '0;
      {st_started, st_quoted, st_closed, st_neg, st_nonempty, st_err} <= '0;
    end else if (acc) begin
      if (finish) begin
        name_length <= '0; name_bad <= 1'b0; phase <= PH_LEAD; pending <= 1'b0;
        arg_value <= '0; aph <= '0;
        {st_started, st_quoted, st_closed, st_neg, st_nonempty, st_err} <= '0;
      end else begin
        case (phase)
          PH_LEAD: begin
            if (eq) phase <= PH_ARG;
            else if (!ws) phase <= PH_NAME;
          end
          PH_NAME: begin
            if (ws) pending <= 1'b1;
            else begin
              if (pending) name_bad <= 1'b1;
              pending <= 1'b0;
              if (eq) phase <= PH_ARG;
            end
          end
          default: begin
            arg_value <= val_next; aph <= a_ph;
            {st_started, st_quoted, st_closed, st_neg, st_nonempty, st_err} <=
              {a_started, a_quoted, a_closed, a_neg, a_nonempty, a_err};
          end
        endcase
        if (append && name_length <= NAME_LEN_W'(NAME_BYTES))
          name_length <= name_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && append && name_length < NAME_LEN_W'(NAME_BYTES))
      name_buffer[name_length[NAME_IDX_W-1:0]] <= header_byte;
  end

endmodule

@@ sv/ccdp_back.sv @@
module ccdp_back import ccdp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_ready,
  input  evt_t evt,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [5:0]  flags, f_next;
  logic [32:0] dur [3];
  logic [32:0] d_next [3];
  logic [32:0] argd;
  logic        acc;

  assign evt_ready = !res_valid || res_ready;
  assign acc = evt_valid && evt_ready;
  assign argd = evt.arg_ok ? {1'b1, evt.arg_val} : 33'd0;

  always_comb begin
    f_next = flags;
    d_next = dur;
    case (evt.id)
      D_NO_CACHE:     f_next[0] = 1'b1;
      D_NO_STORE:     f_next[1] = 1'b1;
      D_NO_TRANSFORM: f_next[2] = 1'b1;
      D_ONLY_IF_CACHED: if (!evt.resp) f_next[3] = 1'b1;
      D_MUST_REVAL, D_PROXY_REVAL: if (evt.resp) f_next[4] = 1'b1;
      D_PRIVATE:  if (evt.resp) f_next[1] = 1'b1;
      D_PUBLIC:   if (evt.resp) f_next[5] = 1'b1;
      D_S_MAXAGE: if (evt.resp) d_next[0] = argd;
      D_MAX_AGE:  if (!evt.resp || !dur[0][32]) d_next[0] = argd;
      D_MIN_FRESH: if (!evt.resp) d_next[1] = argd;
      D_MAX_STALE:
        if (!evt.resp) d_next[2] = evt.arg_nonempty ? argd : {1'b1, NO_LIMIT};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0; dur[0] <= '0; dur[1] <= '0; dur[2] <= '0; res_valid <= 1'b0;
    end else begin
      res_valid <= (acc && evt.last) || (res_valid && !res_ready);
      if (acc) begin
        if (evt.last) begin
          flags <= '0; dur[0] <= '0; dur[1] <= '0; dur[2] <= '0;
        end else begin
          flags <= f_next; dur <= d_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && evt.last) begin
      res.validate_first    <= f_next[0];
      res.store_denied      <= f_next[1];
      res.transform_denied  <= f_next[2];
      res.cached_only       <= f_next[3];
      res.stale_denied      <= f_next[4];
      res.is_public         <= f_next[5];
      res.max_age_present   <= d_next[0][32];
      res.max_age_secs      <= d_next[0][31:0];
      res.min_fresh_present <= d_next[1][32];
      res.min_fresh_secs    <= d_next[1][31:0];
      res.max_stale_present <= d_next[2][32];
      res.max_stale_secs    <= d_next[2][31:0];
    end
  end

  a_present: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.max_age_present || res.max_age_secs == 32'd0))
    else $error("max-age value without presence");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.min_fresh_secs <= SAT_SECS)
    else $error("min-fresh beyond saturation");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result lost under stall");

endmodule

@@ sv/cache_control_directive_parser.sv @@
// cache-control header parser
// in channel: one header byte per transfer with is_response and last_byte;
// valid/ready handshake, one byte accepted every cycle when not stalled
// out channel: one result transfer per header, after the byte with last_byte
// front stage decodes bytes and emits a directive event per comma or last
// byte into a one-entry register; back folds events into flags and durations
// the last byte goes via the front event register, then the back result register
// throughput: one byte per cycle; the name match and multiply-by-ten of the
// argument value sit in the front stage, the flag update in the back stage
// a stalled output holds its result; the back then the front stop taking
// transfers once their registers are full
// reset clears all parse state, flags and durations; no result is pending
module cache_control_directive_parser import ccdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  header_byte,
  input  logic        is_response,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        validate_first,
  output logic        store_denied,
  output logic        transform_denied,
  output logic        cached_only,
  output logic        stale_denied,
  output logic        is_public,
  output logic        max_age_present,
  output logic [31:0] max_age_secs,
  output logic        min_fresh_present,
  output logic [31:0] min_fresh_secs,
  output logic        max_stale_present,
  output logic [31:0] max_stale_secs
);

  logic evt_valid, evt_ready;
  evt_t evt;
  res_t res;

  ccdp_front u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .header_byte, .is_response,
    .last_byte, .evt_valid, .evt_ready, .evt
  );

  ccdp_back u_back (
    .clk, .rst, .evt_valid, .evt_ready, .evt,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign validate_first    = res.validate_first;
  assign store_denied      = res.store_denied;
  assign transform_denied  = res.transform_denied;
  assign cached_only       = res.cached_only;
  assign stale_denied      = res.stale_denied;
  assign is_public         = res.is_public;
  assign max_age_present   = res.max_age_present;
  assign max_age_secs      = res.max_age_secs;
  assign min_fresh_present = res.min_fresh_present;
  assign min_fresh_secs    = res.min_fresh_secs;
  assign max_stale_present = res.max_stale_present;
  assign max_stale_secs    = res.max_stale_secs;

endmodule
